FILE: hdl/assert_macros.svh
// Assertion macros shared by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every edge outside reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hdl/gbba_pkg.sv
// Package of types and constants for the bitmap block allocator
package gbba_pkg;
  localparam int unsigned BLK_W = 18;
  localparam int unsigned GSZ_W = 14;

  typedef enum logic [1:0] {
    REG_GROUP_SIZE    = 2'd0,
    REG_TOTAL_BLOCKS  = 2'd1,
    REG_FIRST_DATA    = 2'd2,
    REG_FREE_AT_START = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_GOAL_RD, ST_GOAL_CHK, ST_SCAN_RD, ST_SCAN_CHK,
    ST_WRITE, ST_RESULT
  } eng_state_t;

  typedef struct packed {
    logic [BLK_W-1:0] goal;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0] allocated_block;
    logic             found;
    logic [GSZ_W-1:0] group_free_left;
    logic [BLK_W-1:0] total_free_left;
  } rsp_t;
endpackage

FILE: hdl/gbba_ram.sv
// Generic single-port RAM with registered read
module gbba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hdl/gbba_front.sv
// Front end: request queue between input port and allocation engine
module gbba_front import gbba_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic q_valid,
  input  logic q_pop,
  output req_t q_req
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  req_t           buf_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           push;

  assign in_ready = (cnt_r != (AW+1)'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_req    = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_req;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (q_pop && q_valid) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_pop && q_valid);
    end
  end
endmodule

FILE: hdl/gbba_engine.sv
// Back end: goal check, word-serial bitmap scan, counters and result register
module gbba_engine import gbba_pkg::*; #(
  parameter int unsigned MAX_GROUPS       = 16,
  parameter int unsigned MAX_GROUP_BLOCKS = 8192,
  parameter int unsigned BITMAP_WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [GSZ_W-1:0] group_size,
  input  logic [BLK_W-1:0] total_blocks,
  input  logic             first_data,
  input  logic [BLK_W-1:0] free_at_start,
  input  logic             q_valid,
  output logic             q_pop,
  input  req_t             q_req,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_rsp,
  output logic             busy
);
  localparam int unsigned MAP_BITS = MAX_GROUPS * MAX_GROUP_BLOCKS;
  localparam int unsigned WORDS    = (MAP_BITS + BITMAP_WORD_BITS - 1) / BITMAP_WORD_BITS;
  localparam int unsigned WA_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BI_W     = $clog2(BITMAP_WORD_BITS);
  localparam int unsigned GB_W     = $clog2(MAX_GROUP_BLOCKS + 1);
  localparam int unsigned OFF_W    = (MAX_GROUP_BLOCKS > 1) ? $clog2(MAX_GROUP_BLOCKS) : 1;
  localparam int unsigned G_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned GC_W     = $clog2(MAX_GROUPS + 1);
  localparam int unsigned IDX_W    = $clog2(MAP_BITS + 1);
  localparam int unsigned W_W      = 40;

  eng_state_t st_r, st_nxt;

  logic [GB_W-1:0]   gs;
  logic [BLK_W-1:0]  data;
  always_comb begin
    if (group_size == '0) gs = GB_W'(1);
    else if (GB_W'(group_size) > GB_W'(MAX_GROUP_BLOCKS)) gs = GB_W'(MAX_GROUP_BLOCKS);
    else gs = GB_W'(group_size);
    data = (total_blocks > BLK_W'(first_data)) ? total_blocks - BLK_W'(first_data) : '0;
  end

  // restoring divider, one quotient bit per cycle
  logic [BLK_W-1:0] dq_r, drem_r;
  logic [4:0]       dcnt_r;
  logic             goal_ok_r;
  logic [BLK_W:0]   dtrial;
  assign dtrial = {drem_r, dq_r[BLK_W-1]} - (BLK_W+1)'(gs);

  // group geometry, tracked by running base
  logic [GC_W-1:0]   g_r;
  logic [BLK_W-1:0]  base_r;
  logic [GB_W-1:0]   bin_cur;
  logic [BLK_W-1:0]  drem_left;
  always_comb begin
    drem_left = data - base_r;
    if (base_r >= data) bin_cur = '0;
    else if (drem_left > BLK_W'(gs)) bin_cur = gs;
    else bin_cur = GB_W'(drem_left);
  end

  logic              goal_chk_r;
  logic [GB_W-1:0]   off_r;
  logic              in_goal_grp_r;

  logic [IDX_W-1:0]  idx;
  assign idx = IDX_W'(g_r) * IDX_W'(MAX_GROUP_BLOCKS) + IDX_W'(off_r);

  logic              we;
  logic [WA_W-1:0]   waddr_r, ram_addr;
  logic [BITMAP_WORD_BITS-1:0] wdata, rdata, word_r;
  logic [BI_W-1:0]   bit_r;

  gbba_ram #(.WIDTH(BITMAP_WORD_BITS), .DEPTH(WORDS)) u_map (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
  );

  logic [GSZ_W-1:0] used_r [MAX_GROUPS];
  logic [BLK_W-1:0] alloc_r;
  logic [WA_W:0]    clr_r;

  rsp_t             rsp_r;
  logic             ov_r;
  logic             wr_flag_r;

  logic [BLK_W-1:0] total_free;
  assign total_free = (free_at_start > alloc_r) ? free_at_start - alloc_r : '0;

  // masked search from current bit within current word
  logic [BITMAP_WORD_BITS-1:0] cand;
  logic                        cand_any;
  logic [BI_W-1:0]             cand_pos;
  logic [GB_W-1:0]             rem_in_grp;
  always_comb begin
    cand     = ~rdata;
    cand_any = 1'b0;
    cand_pos = '0;
    rem_in_grp = bin_cur - off_r;
    for (int i = BITMAP_WORD_BITS-1; i >= 0; i--) begin
      if (cand[i] && (BI_W'(i) >= bit_r) &&
          (GB_W'(i) - GB_W'(bit_r) < rem_in_grp)) begin
        cand_any = 1'b1;
        cand_pos = BI_W'(i);
      end
    end
  end

  logic [BI_W:0] step;
  assign step = (BI_W+1)'(BITMAP_WORD_BITS) - (BI_W+1)'(bit_r);

  logic [GSZ_W-1:0] used_g;
  assign used_g = used_r[G_W'(g_r)];

  assign busy    = (st_r != ST_IDLE);
  assign q_pop   = (st_r == ST_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_rsp   = rsp_r;

  logic wr_done;
  always_comb begin
    st_nxt   = st_r;
    we       = 1'b0;
    ram_addr = WA_W'(idx >> BI_W);
    wdata    = word_r | (BITMAP_WORD_BITS'(1) << bit_r);
    wr_done  = 1'b0;
    unique case (st_r)
      ST_CLEAR: begin
        we = 1'b1; ram_addr = clr_r[WA_W-1:0]; wdata = '0;
        if (clr_r == (WA_W+1)'(WORDS-1)) st_nxt = ST_IDLE;
      end
      ST_IDLE:     if (q_valid) st_nxt = ST_DIV;
      ST_DIV:      if (dcnt_r == 5'(BLK_W)) st_nxt = ST_GOAL_RD;
      ST_GOAL_RD:  st_nxt = goal_chk_r ? ST_GOAL_CHK : ST_SCAN_RD;
      ST_GOAL_CHK: st_nxt = rdata[bit_r] ? ST_SCAN_RD : ST_WRITE;
      ST_SCAN_RD:  begin
        if (g_r >= GC_W'(MAX_GROUPS) || bin_cur == '0) st_nxt = ST_RESULT;
        else if (off_r >= bin_cur) st_nxt = ST_SCAN_RD;
        else st_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: st_nxt = cand_any ? ST_WRITE : ST_SCAN_RD;
      ST_WRITE: begin
        we = 1'b1; ram_addr = waddr_r; wr_done = 1'b1; st_nxt = ST_RESULT;
      end
      ST_RESULT:   if (!ov_r || out_ready) st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_CLEAR;
      clr_r   <= '0;
      alloc_r <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < MAX_GROUPS; i++) used_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (st_r == ST_RESULT && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (q_valid) begin
          dq_r <= q_req.goal - BLK_W'(first_data);
          goal_ok_r <= (q_req.goal >= BLK_W'(first_data));
          drem_r <= '0; dcnt_r <= '0;
        end
        ST_DIV: if (dcnt_r != 5'(BLK_W)) begin
          dcnt_r <= dcnt_r + 1'b1;
          if (!dtrial[BLK_W]) begin
            drem_r <= dtrial[BLK_W-1:0];
            dq_r   <= {dq_r[BLK_W-2:0], 1'b1};
          end else begin
            drem_r <= {drem_r[BLK_W-2:0], dq_r[BLK_W-1]};
            dq_r   <= {dq_r[BLK_W-2:0], 1'b0};
          end
        end else begin
          // dq = goal group, drem = offset
          goal_chk_r <= goal_ok_r && (dq_r < BLK_W'(MAX_GROUPS)) &&
                        (W_W'(dq_r) * W_W'(gs) + W_W'(drem_r) < W_W'(data));
          g_r     <= GC_W'(dq_r);
          base_r  <= BLK_W'(W_W'(dq_r) * W_W'(gs));
          off_r   <= GB_W'(drem_r);
        end
        ST_GOAL_RD: begin
          if (!goal_chk_r) begin
            in_goal_grp_r <= 1'b0; g_r <= '0; base_r <= '0; off_r <= '0; bit_r <= '0;
          end else begin
            bit_r <= BI_W'(idx);
          end
        end
        ST_GOAL_CHK: begin
          word_r <= rdata; waddr_r <= WA_W'(idx >> BI_W);
          if (rdata[bit_r]) begin
            in_goal_grp_r <= 1'b1;
            off_r <= '0; bit_r <= '0;
          end
        end
        ST_SCAN_RD: begin
          bit_r <= BI_W'(idx);
          if (off_r >= bin_cur && bin_cur != '0) begin
            if (in_goal_grp_r) begin
              in_goal_grp_r <= 1'b0; g_r <= '0; base_r <= '0;
            end else begin
              g_r <= g_r + 1'b1; base_r <= base_r + BLK_W'(gs);
            end
            off_r <= '0;
          end
        end
        ST_SCAN_CHK: begin
          word_r <= rdata; waddr_r <= WA_W'(idx >> BI_W);
          if (cand_any) begin
            bit_r <= cand_pos;
            off_r <= off_r + GB_W'(cand_pos) - GB_W'(bit_r);
          end else begin
            off_r <= off_r + GB_W'(step);
          end
        end
        ST_WRITE: begin
          used_r[G_W'(g_r)] <= used_g + 1'b1;
          alloc_r <= alloc_r + 1'b1;
        end
        ST_RESULT: if (!ov_r || out_ready) begin
          rsp_r.total_free_left <= total_free;
          if (wr_flag_r) begin
            rsp_r.found <= 1'b1;
            rsp_r.allocated_block <= BLK_W'(first_data) + base_r + BLK_W'(off_r);
            if (bin_cur > GB_W'(used_g)) rsp_r.group_free_left <= GSZ_W'(bin_cur - GB_W'(used_g));
            else rsp_r.group_free_left <= '0;
          end else begin
            rsp_r.found <= 1'b0; rsp_r.allocated_block <= '0;
            rsp_r.group_free_left <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) wr_flag_r <= 1'b0;
    else if (st_r == ST_IDLE) wr_flag_r <= 1'b0;
    else if (wr_done) wr_flag_r <= 1'b1;
  end
endmodule

FILE: hdl/goal_bitmap_block_allocator_top.sv
// Top level of the goal-directed bitmap block allocator
//   channel | dir | handshake             | payload
//   in      | in  | in_valid / in_ready   | in_goal_block
//   out     | out | out_valid / out_ready | allocated_block, found, free counts
//   cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
// Reset clears the bitmap one word a cycle, 4096 words, and the engine takes no request until the clear is done.
// Per request: group divide, goal read and check, then a scan that reads and checks each bitmap
// word in turn and steps group by group, all through the single bitmap RAM port.
// A two-word queue takes words while the engine works or the result stalls.
`include "assert_macros.svh"
module goal_bitmap_block_allocator_top import gbba_pkg::*; #(
  parameter int unsigned MAX_GROUPS       = 16,
  parameter int unsigned MAX_GROUP_BLOCKS = 8192,
  parameter int unsigned BITMAP_WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [BLK_W-1:0] in_goal_block,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [BLK_W-1:0] out_allocated_block,
  output logic             out_found,
  output logic [GSZ_W-1:0] out_group_free_left,
  output logic [BLK_W-1:0] out_total_free_left,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [BLK_W-1:0] cfg_data
);
  logic [GSZ_W-1:0] group_size_r;
  logic [BLK_W-1:0] total_blocks_r, free_at_start_r;
  logic             first_data_r;
  logic             q_valid, q_pop, busy;
  req_t             q_req, in_req;
  rsp_t             rsp;
  logic             fail_clean;

  assign cfg_ready = 1'b1;
  assign in_req.goal = in_goal_block;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r    <= GSZ_W'(8192);
      total_blocks_r  <= BLK_W'(131072);
      first_data_r    <= 1'b0;
      free_at_start_r <= BLK_W'(131072);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GROUP_SIZE:    group_size_r    <= cfg_data[GSZ_W-1:0];
        REG_TOTAL_BLOCKS:  total_blocks_r  <= cfg_data;
        REG_FIRST_DATA:    first_data_r    <= cfg_data[0];
        REG_FREE_AT_START: free_at_start_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gbba_front #(.DEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
  );

  gbba_engine #(
    .MAX_GROUPS(MAX_GROUPS), .MAX_GROUP_BLOCKS(MAX_GROUP_BLOCKS),
    .BITMAP_WORD_BITS(BITMAP_WORD_BITS)
  ) u_engine (
    .clk(clk), .rst_n(rst_n), .group_size(group_size_r),
    .total_blocks(total_blocks_r), .first_data(first_data_r),
    .free_at_start(free_at_start_r), .q_valid(q_valid), .q_pop(q_pop),
    .q_req(q_req), .out_valid(out_valid), .out_ready(out_ready),
    .out_rsp(rsp), .busy(busy)
  );

  assign out_allocated_block = rsp.allocated_block;
  assign out_found           = rsp.found;
  assign out_group_free_left = rsp.group_free_left;
  assign out_total_free_left = rsp.total_free_left;

  assign fail_clean = (out_allocated_block == '0) && (out_group_free_left == '0);

  `ASSERT_IMP(a_pop_idle, q_pop, q_valid && !busy)
  `ASSERT_IMP(a_fail_zero, out_valid && !out_found, fail_clean)
  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

FILE: verif/testbench.sv
// Testbench for the goal-directed bitmap block allocator: directed and random requests
`timescale 1ns / 1ps
module testbench;
  import gbba_pkg::*;

  localparam int unsigned NGRP = 16;
  localparam int unsigned GBLK = 8192;
  localparam int unsigned MAP_BITS = NGRP * GBLK;
  localparam int unsigned LIMIT = 3000000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [BLK_W-1:0] in_goal_block = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [BLK_W-1:0] out_allocated_block;
  logic             out_found;
  logic [GSZ_W-1:0] out_group_free_left;
  logic [BLK_W-1:0] out_total_free_left;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [BLK_W-1:0] cfg_data = '0;

  goal_bitmap_block_allocator_top dut (.*);

  // allocator image
  bit          used_map [MAP_BITS];
  int unsigned grp_used [NGRP];
  int unsigned alloc_total;
  int unsigned grp_size_r, total_r, first_r, free_start_r;

  logic [BLK_W-1:0] goal_q [$];
  rsp_t             grant_q [$];

  int unsigned fails = 0;
  int unsigned cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_done = 0;
  bit          calm = 1'b0;

  function automatic int unsigned blocks_in(int unsigned g, int unsigned gs, int unsigned dat);
    int unsigned base;
    base = g * gs;
    if (base >= dat) return 0;
    return (dat - base) > gs ? gs : dat - base;
  endfunction

  function automatic int scan_grp(int unsigned g, int unsigned gs, int unsigned dat);
    int unsigned n;
    n = blocks_in(g, gs, dat);
    for (int unsigned i = 0; i < n; i++)
      if (!used_map[g * GBLK + i]) return int'(i);
    return -1;
  endfunction

  function automatic rsp_t take_block(logic [BLK_W-1:0] goal);
    int unsigned gs, dat, ng, rel, gg, go, rg, roff, bin, g;
    int f;
    bit have;
    rsp_t r;
    gs = grp_size_r == 0 ? 1 : (grp_size_r > GBLK ? GBLK : grp_size_r);
    dat = total_r > first_r ? total_r - first_r : 0;
    ng = (dat + gs - 1) / gs;
    if (ng > NGRP) ng = NGRP;
    have = 1'b0;
    rg = 0;
    roff = 0;
    if (goal >= first_r) begin
      rel = goal - first_r;
      gg = rel / gs;
      go = rel % gs;
      if (gg < ng && go < blocks_in(gg, gs, dat)) begin
        if (!used_map[gg * GBLK + go]) begin
          have = 1'b1; rg = gg; roff = go;
        end else begin
          f = scan_grp(gg, gs, dat);
          if (f >= 0) begin
            have = 1'b1; rg = gg; roff = f;
          end
        end
      end
    end
    for (g = 0; !have && g < ng; g++) begin
      f = scan_grp(g, gs, dat);
      if (f >= 0) begin
        have = 1'b1; rg = g; roff = f;
      end
    end
    r = '0;
    if (have) begin
      used_map[rg * GBLK + roff] = 1'b1;
      grp_used[rg] = (grp_used[rg] + 1) & 32'h3FFF;
      alloc_total = (alloc_total + 1) & 32'h3FFFF;
      bin = blocks_in(rg, gs, dat);
      r.allocated_block = BLK_W'(first_r + rg * gs + roff);
      r.found = 1'b1;
      r.group_free_left = GSZ_W'(bin > grp_used[rg] ? bin - grp_used[rg] : 0);
    end
    r.total_free_left = BLK_W'(free_start_r > alloc_total ? free_start_r - alloc_total : 0);
    return r;
  endfunction

  initial begin
    forever #4 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (in_valid && in_ready) grant_q.push_back(take_block(in_goal_block));
    if (rst_n && !(in_valid && !in_ready)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (goal_q.size() > 0) begin
        in_valid <= 1'b1;
        in_goal_block <= goal_q.pop_front();
        if (!calm && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    rsp_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        $error("word with no grant pending");
        fails++;
      end else begin
        e = grant_q.pop_front();
        if (out_allocated_block !== e.allocated_block) begin
          $error("allocated_block exp %0d got %0d", e.allocated_block, out_allocated_block);
          fails++;
        end
        if (out_found !== e.found) begin
          $error("found exp %0d got %0d", e.found, out_found);
          fails++;
        end
        if (out_group_free_left !== e.group_free_left) begin
          $error("group_free_left exp %0d got %0d", e.group_free_left, out_group_free_left);
          fails++;
        end
        if (out_total_free_left !== e.total_free_left) begin
          $error("total_free_left exp %0d got %0d", e.total_free_left, out_total_free_left);
          fails++;
        end
      end
    end
    if (rst_n) begin
      if (hold_done != hold_req) begin
        hold_done <= hold_req;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= BLK_W'(val);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_GROUP_SIZE:    grp_size_r = val & 32'h3FFF;
      REG_TOTAL_BLOCKS:  total_r = val & 32'h3FFFF;
      REG_FIRST_DATA:    first_r = val & 1;
      REG_FREE_AT_START: free_start_r = val & 32'h3FFFF;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned gs, int unsigned tot, int unsigned fd,
                              int unsigned fr);
    write_reg(REG_GROUP_SIZE, gs);
    write_reg(REG_TOTAL_BLOCKS, tot);
    write_reg(REG_FIRST_DATA, fd);
    write_reg(REG_FREE_AT_START, fr);
  endtask

  task automatic drain();
    do @(negedge clk); while (goal_q.size() > 0 || in_valid || grant_q.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    grp_size_r = 8192;
    total_r = 131072;
    first_r = 0;
    free_start_r = 131072;
    alloc_total = 0;
    foreach (grp_used[i]) grp_used[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: hits, repeat goals, goals past the end
    foreach (goal_q[i]) ;
    goal_q = '{0, 0, 5, 5, 8191, 8192, 131071, 131072, 18'h3FFFF, 0, 1, 70000};
    drain();

    // unit groups, too many groups, tiny free count: free count runs out
    set_geometry(0, 20, 1, 3);
    for (int i = 0; i < 14; i++) goal_q.push_back($urandom_range(0, 25));
    drain();

    // empty data area
    set_geometry(8, 1, 1, 0);
    repeat (3) goal_q.push_back($urandom_range(0, 4));
    drain();

    // oversized group, largest volume; long receiver hold
    set_geometry(16383, 131073, 0, 131072);
    hold_req++;
    for (int i = 0; i < 600; i++)
      goal_q.push_back($urandom_range(0, 1) ? $urandom_range(0, 131072) : $urandom_range(0, 40));
    drain();

    // small volumes, frequent full
    for (int p = 0; p < 4; p++) begin
      set_geometry($urandom_range(1, 12), $urandom_range(0, 120), $urandom_range(0, 1),
                   $urandom_range(0, 100));
      for (int i = 0; i < 100; i++) goal_q.push_back($urandom_range(0, 130));
      drain();
    end

    // mid-size geometry, quiet tail
    set_geometry(1000, 20000, 1, 19000);
    for (int i = 0; i < 500; i++)
      goal_q.push_back($urandom_range(0, 3) == 0 ? $urandom_range(0, 262143)
                                                 : $urandom_range(0, 21000));
    drain();
    calm = 1'b1;
    set_geometry(4096, 65536, 0, 65536);
    for (int i = 0; i < 400; i++) goal_q.push_back($urandom_range(0, 70000));
    drain();

    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
